[rtl/dru_pkg.sv]
// Package for the dense rank block: sizes, payload types and the structs
// passed between the sequencer, the compare unit and the value memory.
// No dependencies.
package dru_pkg;

	localparam int MAX_ELEMS  = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = $clog2(MAX_ELEMS);
	localparam int CNT_W      = $clog2(MAX_ELEMS + 1);
	localparam int RANK_W     = 6;
	localparam int WORD_W     = VALUE_BITS + 1;
	localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((RANK_W + 7) / 8) * 8;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [RANK_W-1:0]     rank_t;

	typedef struct packed {
		logic   valid;
		value_t ref_val;
	} cmp_req_t;

	typedef struct packed {
		logic valid;
		logic eq;
		logic lt;
		logic first;
	} cmp_res_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} mem_wr_t;

endpackage

[rtl/dru_ram.sv]
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module dru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/dru_cmp.sv]
// Shared compare unit: equality and less-than of a memory word against the
// held reference value, registered. Depends on dru_pkg.
module dru_cmp import dru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmp_req_t req,
	input  word_t    word,
	output cmp_res_t res
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
			res.eq    <= 1'b0;
			res.lt    <= 1'b0;
			res.first <= 1'b0;
		end else begin
			res.valid <= req.valid;
			res.eq    <= word[VALUE_BITS-1:0] == req.ref_val;
			res.lt    <= word[VALUE_BITS-1:0] <  req.ref_val;
			res.first <= word[VALUE_BITS];
		end
	end

endmodule

[rtl/dru_ctrl.sv]
// Sequencer of the dense rank block: load, first-occurrence pass, rank pass
// and output register. Drives the value memory and the compare unit.
// Depends on dru_pkg.
module dru_ctrl import dru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  value_t   s_value,
	input  logic     s_last,
	output logic     m_tvalid,
	input  logic     m_tready,
	output rank_t    m_rank,
	output logic     m_last,
	output logic     m_ovf,
	output mem_wr_t  wr,
	output idx_t     rd_addr,
	input  word_t    rd_data,
	output cmp_req_t req,
	input  cmp_res_t res
);

	typedef enum logic [3:0] {
		S_LOAD, S_A_RD, S_A_LATCH, S_A_SWEEP, S_A_WB,
		S_B_RD, S_B_LATCH, S_B_SWEEP, S_EMIT
	} state_t;

	state_t state_q;
	cnt_t   cnt_q, n_q, lim_q, k_q;
	idx_t   o_q;
	value_t x_q;
	logic   first_q, ovf_q;
	rank_t  rank_q;
	logic   issue_s1;
	logic   m_valid_q, m_last_q, m_ovf_q;
	rank_t  m_rank_q;

	logic full, in_beat, sweep_st, issuing, sweep_done, o_last, out_free, emit;

	assign full       = cnt_q == CNT_W'(MAX_ELEMS);
	assign s_tready   = state_q == S_LOAD;
	assign in_beat    = s_tvalid && s_tready;
	assign sweep_st   = (state_q == S_A_SWEEP) || (state_q == S_B_SWEEP);
	assign issuing    = sweep_st && (k_q != lim_q);
	assign sweep_done = (k_q == lim_q) && !issue_s1 && !res.valid;
	assign o_last     = (CNT_W'(o_q) + CNT_W'(1)) == n_q;
	assign out_free   = !m_valid_q || m_tready;
	assign emit       = (state_q == S_EMIT) && out_free;

	assign wr.en   = (in_beat && !full) || (state_q == S_A_WB);
	assign wr.addr = (state_q == S_A_WB) ? o_q : cnt_q[IDX_W-1:0];
	assign wr.data = (state_q == S_A_WB) ? {first_q, x_q} : {1'b0, s_value};

	assign rd_addr = ((state_q == S_A_RD) || (state_q == S_B_RD)) ? o_q : k_q[IDX_W-1:0];

	assign req.valid   = issue_s1;
	assign req.ref_val = x_q;

	assign m_tvalid = m_valid_q;
	assign m_rank   = m_rank_q;
	assign m_last   = m_last_q;
	assign m_ovf    = m_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			n_q       <= '0;
			lim_q     <= '0;
			k_q       <= '0;
			o_q       <= '0;
			ovf_q     <= 1'b0;
			first_q   <= 1'b0;
			rank_q    <= '0;
			issue_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
			m_ovf_q   <= 1'b0;
			m_rank_q  <= '0;
			x_q       <= '0;
		end else begin
			issue_s1 <= issuing;
			if (issuing) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (m_tready && !emit) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (s_tvalid) begin
						if (!full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_last) begin
							n_q     <= full ? cnt_q : cnt_q + CNT_W'(1);
							o_q     <= '0;
							state_q <= S_A_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_LATCH;
				end
				S_A_LATCH: begin
					x_q     <= rd_data[VALUE_BITS-1:0];
					first_q <= 1'b1;
					k_q     <= '0;
					lim_q   <= CNT_W'(o_q);
					state_q <= S_A_SWEEP;
				end
				S_A_SWEEP: begin
					if (res.valid && res.eq) begin
						first_q <= 1'b0;
					end
					if (sweep_done) begin
						state_q <= S_A_WB;
					end
				end
				S_A_WB: begin
					if (o_last) begin
						o_q     <= '0;
						state_q <= S_B_RD;
					end else begin
						o_q     <= o_q + IDX_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_B_RD: begin
					state_q <= S_B_LATCH;
				end
				S_B_LATCH: begin
					x_q     <= rd_data[VALUE_BITS-1:0];
					rank_q  <= '0;
					k_q     <= '0;
					lim_q   <= n_q;
					state_q <= S_B_SWEEP;
				end
				S_B_SWEEP: begin
					if (res.valid && res.first && res.lt) begin
						rank_q <= rank_q + RANK_W'(1);
					end
					if (sweep_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_rank_q  <= rank_q;
						m_last_q  <= o_last;
						m_ovf_q   <= ovf_q;
						if (o_last) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							o_q     <= o_q + IDX_W'(1);
							state_q <= S_B_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ELEMS))
		else $error("element count above capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flagged while store not full");

	a_res_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> sweep_st)
		else $error("compare result outside a sweep");

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_st |-> (k_q <= lim_q))
		else $error("sweep index past its limit");

	a_end_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free && o_last) |=> (state_q == S_LOAD && cnt_q == '0))
		else $error("vector not closed after final rank");

endmodule

[rtl/dense_rank_unique_index.sv]
// Top level of the dense rank block: value memory, shared compare unit and
// sequencer. Depends on dru_pkg, dru_ram, dru_cmp and dru_ctrl.
//
// Usage:
//   The slave channel loads one unsigned value per beat (s_tdata), s_tlast
//   on the final beat of a vector. Up to MAX_ELEMS values are stored; later
//   beats are dropped and set the overflow flag.
//   After the final beat, s_tready stays low while the block ranks. The
//   master channel then gives one beat per stored element in load order:
//   m_tdata holds the dense rank, m_tlast marks the last element, m_tuser
//   the overflow flag. Loading resumes after the last rank is registered.
// Timing:
//   Loading accepts one beat per cycle. For n stored elements, ranking runs
//   on the single compare unit walking the memory over one read port:
//   a first-occurrence pass (n*(n-1)/2 compares) and a rank pass (n*n
//   compares).
// Reset clears the element count, overflow flag and output valid at once.
// A stalled master holds the registered rank; the rank pass waits for it.
module dense_rank_unique_index import dru_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [31:0] value
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [5:0] rank, [7:6] zero
	output logic                  m_tlast,
	output logic                  m_tuser   // [0] overflow
);

	mem_wr_t  wr;
	idx_t     rd_addr;
	word_t    rd_data;
	cmp_req_t req;
	cmp_res_t res;
	rank_t    m_rank;

	dru_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_ELEMS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dru_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.word   (rd_data),
		.res    (res)
	);

	dru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_value  (s_tdata[VALUE_BITS-1:0]),
		.s_last   (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_rank   (m_rank),
		.m_last   (m_tlast),
		.m_ovf    (m_tuser),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.req      (req),
		.res      (res)
	);

	assign m_tdata = OUT_DATA_W'(m_rank);

endmodule

[dv/dru_rank_checker.sv]
// Checker for the dense rank block: watches the load and rank channels,
// predicts each vector's dense ranks and compares every rank beat.
// Depends on dru_pkg.
module dru_rank_checker import dru_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  m_tlast,
	input  logic                  m_tuser,
	output int                    errors,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rank_t rank;
		logic  is_last;
		logic  overflow;
	} rank_beat_t;

	value_t     loaded_values [MAX_ELEMS];
	int         loaded_count;
	logic       dropped_any;
	rank_beat_t expected_ranks [$];

	initial begin
		errors = 0;
		outstanding = 0;
		loaded_count = 0;
		dropped_any = 1'b0;
	end

	function automatic rank_t dense_rank_of(int idx);
		int  r;
		bit  seen;
		r = 0;
		for (int j = 0; j < loaded_count; j++) begin
			if (loaded_values[j] < loaded_values[idx]) begin
				seen = 1'b0;
				for (int k = 0; k < j; k++)
					if (loaded_values[k] == loaded_values[j])
						seen = 1'b1;
				if (!seen)
					r++;
			end
		end
		return rank_t'(r);
	endfunction

	task automatic rank_loaded_vector();
		rank_beat_t b;
		for (int i = 0; i < loaded_count; i++) begin
			b.rank = dense_rank_of(i);
			b.is_last = (i == loaded_count - 1);
			b.overflow = dropped_any;
			expected_ranks.push_back(b);
		end
		loaded_count = 0;
		dropped_any = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_beat_t want;
		if (!arst_n) begin
			loaded_count = 0;
			dropped_any = 1'b0;
			expected_ranks.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (loaded_count < MAX_ELEMS) begin
					loaded_values[loaded_count] = s_tdata[VALUE_BITS-1:0];
					loaded_count++;
				end else begin
					dropped_any = 1'b1;
				end
				if (s_tlast)
					rank_loaded_vector();
			end
			if (m_tvalid && m_tready) begin
				if (expected_ranks.size() == 0) begin
					$error("unexpected rank beat: rank %0d, last %0b, overflow %0b",
						m_tdata[RANK_W-1:0], m_tlast, m_tuser);
					errors++;
				end else begin
					want = expected_ranks.pop_front();
					if (m_tdata[RANK_W-1:0] !== want.rank) begin
						$error("rank: expected %0d, actual %0d", want.rank,
							m_tdata[RANK_W-1:0]);
						errors++;
					end
					if (m_tlast !== want.is_last) begin
						$error("last_out: expected %0b, actual %0b", want.is_last, m_tlast);
						errors++;
					end
					if (m_tuser !== want.overflow) begin
						$error("overflow: expected %0b, actual %0b", want.overflow, m_tuser);
						errors++;
					end
				end
			end
			outstanding = expected_ranks.size();
		end
	end

endmodule

[dv/tb.sv]
// Testbench top for the dense rank block: clock, reset, vector stimulus with
// random gaps and back-pressure, and the final verdict.
// Depends on dru_pkg, dense_rank_unique_index and dru_rank_checker.
module tb;
	import dru_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_ITEMS = 380;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	int                    errors;
	int                    outstanding;

	value_t      vector_q [$];
	value_t      value_pool [4];
	int          items_sent = 0;
	bit          burst_mode = 1'b0;
	int unsigned ready_hold = 0;
	int unsigned ready_phase = 0;
	bit          ready_free = 1'b0;

	dense_rank_unique_index uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	dru_rank_checker rank_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser), .errors(errors), .outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#7_200_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (ready_phase == 0) begin
			ready_free = ($urandom_range(0, 3) == 0);
			ready_phase = $urandom_range(50, 300);
		end else begin
			ready_phase--;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (ready_hold != 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else if (ready_free || r < 65) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			ready_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
		end
	end

	function automatic int beat_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(input value_t v, input logic is_last);
		int gap;
		gap = beat_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(v);
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic load_vector();
		burst_mode = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < vector_q.size(); i++)
			send_beat(vector_q[i], i == vector_q.size() - 1);
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
	endtask

	function automatic value_t pick_value(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 7);
			2: return value_pool[$urandom_range(0, 3)];
			default: begin
				case ($urandom_range(0, 2))
					0: return '0;
					1: return '1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic build_vector(input int len, input int mode);
		for (int p = 0; p < 4; p++)
			value_pool[p] = $urandom;
		vector_q.delete();
		for (int i = 0; i < len; i++)
			vector_q.push_back(pick_value(mode));
	endtask

	initial begin
		int vec_num;
		int len;
		int r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		vector_q = '{32'hFFFF_FFFF};
		load_vector();
		vector_q = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000};
		load_vector();
		vector_q = '{32'd5, 32'd5, 32'd5};
		load_vector();
		vector_q = '{32'd4, 32'd3, 32'd2, 32'd1, 32'd0};
		load_vector();
		vector_q = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
		load_vector();
		vector_q = '{32'h0};
		load_vector();

		vec_num = 0;
		while (items_sent < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (vec_num == 3)
				len = MAX_ELEMS;
			else if (vec_num == 9)
				len = MAX_ELEMS + 2;
			else if (vec_num == 18)
				len = MAX_ELEMS + 6;
			else if (r < 3)
				len = $urandom_range(MAX_ELEMS - 4, MAX_ELEMS + 4);
			else if (r < 12)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(1, 12);
			build_vector(len, (vec_num == 3) ? 0 : $urandom_range(0, 3));
			load_vector();
			vec_num++;
		end

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
